@@ rtl/hsadl_pkg.sv @@
package hsadl_pkg;

  localparam int KEY_W  = 64;
  localparam int MODE_W = 2;

  // default table shape
  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS_DEF    = 4;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_ADD    = 2'd0;
  localparam mode_t MODE_DEL    = 2'd1;
  localparam mode_t MODE_SEARCH = 2'd2;

endpackage

@@ rtl/hsadl_mod.sv @@
// Remainder of a 64-bit key by BUCKETS on one shared multiplier.
// Fold steps replace the upper 32 bits by their weight (2^32 mod BUCKETS)
// until the value fits in 32 bits. A reciprocal multiply then estimates
// the quotient, at most one low; a multiply back and one compare/subtract
// give the remainder. done pulses in the cycle after the last step.
module hsadl_mod #(
  parameter int BUCKETS = hsadl_pkg::BUCKETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [hsadl_pkg::KEY_W-1:0]      key,
  output logic                             done,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] rem
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  // reciprocal scale; 2^K / BUCKETS fits in 33 bits
  localparam int K = 32 + $clog2(BUCKETS);
  localparam logic [63:0] FOLD_W = (64'd1 << 32) % 64'(BUCKETS);
  localparam logic [63:0] RECIP  = (64'd1 << K) / 64'(BUCKETS);

  localparam logic [1:0] PH_FOLD = 2'd0;
  localparam logic [1:0] PH_BACK = 2'd1;
  localparam logic [1:0] PH_FIX  = 2'd2;
  localparam logic [1:0] PH_IDLE = 2'd3;

  logic [1:0]                  phase;
  logic [hsadl_pkg::KEY_W-1:0] x;
  logic                        wide;
  logic [31:0]                 q;
  logic [BW:0]                 t;
  logic [31:0]                 mul_a;
  logic [32:0]                 mul_b;
  logic [64:0]                 prod;

  assign wide = (x[hsadl_pkg::KEY_W-1:32] != 32'd0);

  // shared multiplier: fold weight, reciprocal, or quotient times BUCKETS
  always_comb begin
    mul_a = x[31:0];
    mul_b = RECIP[32:0];
    if (phase == PH_BACK) begin
      mul_a = q;
      mul_b = 33'(BUCKETS);
    end else if (wide) begin
      mul_a = x[hsadl_pkg::KEY_W-1:32];
      mul_b = FOLD_W[32:0];
    end
  end

  assign prod = 65'(mul_a) * 65'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == PH_FIX);
      if (start) begin
        phase <= PH_FOLD;
      end else begin
        unique case (phase)
          PH_FOLD: begin
            if (!wide) begin
              phase <= PH_BACK;
            end
          end
          PH_BACK: begin
            phase <= PH_FIX;
          end
          PH_FIX: begin
            phase <= PH_IDLE;
          end
          PH_IDLE: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= key;
    end else if (phase == PH_FOLD) begin
      if (wide) begin
        x <= 64'(prod) + {32'd0, x[31:0]};
      end else begin
        q <= 32'(prod >> K);
      end
    end else if (phase == PH_BACK) begin
      // true difference is below 2*BUCKETS, so the low bits are exact
      t <= x[BW:0] - prod[BW:0];
    end else if (phase == PH_FIX) begin
      if (t >= (BW+1)'(BUCKETS)) begin
        rem <= BW'(t - (BW+1)'(BUCKETS));
      end else begin
        rem <= t[BW-1:0];
      end
    end
  end

endmodule

@@ rtl/hash_set_add_delete_lookup.sv @@
// Hash set of 64-bit unsigned keys with BUCKETS buckets of WAYS slots each.
// Input stream (s_*): one request per accepted beat, carrying mode (add,
// delete, search; the unused code acts as search) and the key.
// Output stream (m_*): one result per request: found (key was present
// before the request) and overflow (add met a full bucket, key dropped).
// Requests are handled one at a time; s_tready is high only when idle.
// The bucket remainder comes from one shared multiplier, in fold steps
// whose number depends on the key (0 or 1 with a power-of-two BUCKETS).
// Each way of the bucket then takes one table read and one compare.
// A new request is accepted only once the previous result has been
// loaded into the output register.
// Reset: a clearing pass writes every slot invalid; s_tready stays low
// until it is done.
// The result sits in an output register; a stalled receiver (m_tready low)
// holds it, and the next request may be accepted and worked on meanwhile,
// its result waiting until the register frees up.
module hash_set_add_delete_lookup #(
  parameter int BUCKETS = hsadl_pkg::BUCKETS_DEF,
  parameter int WAYS    = hsadl_pkg::WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [1:0] mode, [65:2] key, [71:66] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] found, [1] overflow, [7:2] zero
);

  localparam int KW    = hsadl_pkg::KEY_W;
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_ACT  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]           state;
  hsadl_pkg::mode_t     mode_r;
  logic [KW-1:0]        key_r;
  logic [AW-1:0]        addr;
  logic [WW-1:0]        way;
  logic                 hit;
  logic [AW-1:0]        hit_addr;
  logic                 free;
  logic [AW-1:0]        free_addr;
  logic                 found;
  logic                 overflow;

  logic                 mod_done;
  logic [BW-1:0]        mod_rem;

  // table: top bit is the slot's valid mark, low bits the key
  logic [KW:0]          mem [SLOTS];
  logic [KW:0]          rdata;
  logic [AW-1:0]        mem_addr;
  logic                 mem_we;
  logic [KW:0]          mem_wdata;
  logic                 do_add;
  logic                 do_del;

  logic s_accept;
  logic slot_match;
  logic out_load;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign m_tdata  = {6'd0, overflow, found};
  // result register loads in the result step when it is empty or being drained this cycle
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  hsadl_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (s_accept),
    .key   (s_tdata[65:2]),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // per-request action, decided once the scan is complete
  always_comb begin
    do_add = 1'b0;
    do_del = 1'b0;
    unique case (mode_r)
      hsadl_pkg::MODE_ADD:    do_add = !hit && free;
      hsadl_pkg::MODE_DEL:    do_del = hit;
      hsadl_pkg::MODE_SEARCH: ;
      default:                ;   // unused code behaves as search
    endcase
  end

  assign slot_match = rdata[KW] && (rdata[KW-1:0] == key_r);

  // single port: clear sweep, action write, or scan read
  always_comb begin
    mem_addr  = addr;
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (state == ST_CLR) begin
      mem_we = 1'b1;
    end else if (state == ST_ACT) begin
      mem_addr  = hit ? hit_addr : free_addr;
      mem_we    = do_add || do_del;
      mem_wdata = {do_add, key_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      addr     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      unique case (state)
        ST_CLR: begin
          if (addr == AW'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            addr  <= AW'(mod_rem) * AW'(WAYS);
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (way == WW'(WAYS - 1)) begin
            state <= ST_ACT;
          end else begin
            addr  <= addr + AW'(1);
            state <= ST_RD;
          end
        end
        ST_ACT: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request payload, scan bookkeeping and result
  always_ff @(posedge clk) begin
    if (s_accept) begin
      mode_r <= s_tdata[1:0];
      key_r  <= s_tdata[65:2];
      hit    <= 1'b0;
      free   <= 1'b0;
      way    <= '0;
    end
    if (state == ST_CMP) begin
      way <= way + WW'(1);
      if (slot_match) begin
        hit      <= 1'b1;
        hit_addr <= addr;
      end
      // lowest free way wins
      if (!rdata[KW] && !free) begin
        free      <= 1'b1;
        free_addr <= addr;
      end
    end
    if (out_load) begin
      found    <= hit;
      overflow <= (mode_r == hsadl_pkg::MODE_ADD) && !hit && !free;
    end
  end

  // remainder unit finishes only while the sequencer waits for it
  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == ST_MOD)
    else $error("bucket remainder finished outside its wait state");

  // table written only by the clearing sweep or the action step
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLR || state == ST_ACT))
    else $error("table write outside clear or action step");

  // a dropped add never reports the key as present
  a_ovf_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("overflow raised together with found");

  // a new result appears only from the result step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_OUT)
    else $error("result raised outside the result step");

endmodule

@@ tb/hash_set_add_delete_lookup_test.sv @@
`timescale 1ns / 100ps

module hash_set_add_delete_lookup_test;

  localparam int TB_BUCKETS = hsadl_pkg::BUCKETS_DEF;
  localparam int TB_WAYS    = hsadl_pkg::WAYS_DEF;
  localparam int TB_SLOTS   = TB_BUCKETS * TB_WAYS;
  // the spare mode code; the block treats it as a search
  localparam hsadl_pkg::mode_t MODE_SPARE = 2'd3;
  // allowance for accept to result, used to size the waits below
  localparam int LATENCY      = 11 + 2 * TB_WAYS;
  localparam int MAX_WAIT     = 18;
  // clearing pass after reset, plus one slow request, taken several times over
  localparam int IDLE_LIMIT   = 4 * (TB_SLOTS + LATENCY + 2 * MAX_WAIT + 8);
  localparam int RANDOM_COUNT = 1030;
  localparam int POOL_DEPTH   = 48;

  typedef struct packed {
    logic found;
    logic overflow;
  } set_flags_t;

  // Shadow copy of the table; predicts found/overflow for each accepted
  // request and checks results in order.
  class set_shadow;
    logic [63:0]  key_at [TB_SLOTS];
    bit           held   [TB_SLOTS];
    set_flags_t   expected_flags [$];
    int unsigned  requests, results, errors, hits, overflows;

    function void note_request(hsadl_pkg::mode_t op, logic [63:0] key);
      int unsigned base, w, hit_way, free_way;
      set_flags_t  f;
      base     = int'(key % TB_BUCKETS) * TB_WAYS;
      hit_way  = TB_WAYS;
      free_way = TB_WAYS;
      for (w = 0; w < TB_WAYS; w++) begin
        if (held[base + w]) begin
          // only valid slots are compared; unwritten keys are never looked at
          if (key_at[base + w] == key && hit_way == TB_WAYS) hit_way = w;
        end else if (free_way == TB_WAYS) begin
          free_way = w;
        end
      end
      f.found    = (hit_way < TB_WAYS);
      f.overflow = 1'b0;
      if (op == hsadl_pkg::MODE_ADD && !f.found) begin
        // lowest free way wins; full bucket drops the key
        if (free_way < TB_WAYS) begin
          key_at[base + free_way] = key;
          held[base + free_way]   = 1'b1;
        end else begin
          f.overflow = 1'b1;
        end
      end else if (op == hsadl_pkg::MODE_DEL && f.found) begin
        held[base + hit_way] = 1'b0;
      end
      // search and the spare code leave the table alone
      requests++;
      if (f.found) hits++;
      if (f.overflow) overflows++;
      expected_flags.push_back(f);
    endfunction

    function void check_result(logic found, logic overflow);
      set_flags_t f;
      results++;
      if (expected_flags.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: found %b overflow %b",
                 $time, found, overflow);
        return;
      end
      f = expected_flags.pop_front();
      if (found !== f.found) begin
        errors++;
        $display("%0t: found expected %b actual %b", $time, f.found, found);
      end
      if (overflow !== f.overflow) begin
        errors++;
        $display("%0t: overflow expected %b actual %b", $time, f.overflow, overflow);
      end
    endfunction

    function int unsigned pending();
      return expected_flags.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // [1:0] mode, [65:2] key, [71:66] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] found, [1] overflow, [7:2] zero

  set_shadow   table_shadow = new();
  logic [63:0] key_pool [$];     // keys recently sent as adds, reused for hits
  int unsigned spare_mode_count;
  int unsigned idle_cycles;
  bit          src_calm;
  bit          sink_calm;

  // a few buckets get most of the traffic so they fill and overflow
  int unsigned hot_bucket [6] = '{0, 1, 7, TB_BUCKETS / 2, TB_BUCKETS - 2, TB_BUCKETS - 1};

  hash_set_add_delete_lookup uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Random wait, with a bias to back-to-back; calm stretches never wait
  function automatic int draw_wait(bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // One request: optional gap, then hold valid until the handshake edge.
  // Valid stays high across back-to-back requests (single NBA per step).
  task automatic send_request(hsadl_pkg::mode_t op, logic [63:0] key);
    int gap;
    gap = draw_wait(src_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, key, op};
    do @(posedge clk); while (!s_tready);
    if (op == hsadl_pkg::MODE_ADD) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end
  endtask

  // Mostly keys already in play or landing in hot buckets; the rest fully random.
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 45 && key_pool.size() > 0) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else begin
      k = {$urandom, $urandom};
      if (r < 80) k = k - (k % TB_BUCKETS) + hot_bucket[$urandom_range(0, 5)];
    end
    return k;
  endfunction

  function automatic hsadl_pkg::mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return hsadl_pkg::MODE_ADD;
    if (r < 68) return hsadl_pkg::MODE_DEL;
    if (r < 94) return hsadl_pkg::MODE_SEARCH;
    return MODE_SPARE;
  endfunction

  // Sink side: random stall before each result, calm stretches in between.
  initial begin
    int stall;
    int left;
    left = 0;
    @(posedge clk);
    forever begin
      if (left == 0) begin
        sink_calm = ($urandom_range(0, 4) == 0);
        left = $urandom_range(8, 40);
      end
      left--;
      stall = draw_wait(sink_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && !rst));
    end
  end

  // Handshake monitor; results are checked before the same-edge request is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) table_shadow.check_result(m_tdata[0], m_tdata[1]);
      if (s_tvalid && s_tready) begin
        table_shadow.note_request(s_tdata[1:0], s_tdata[65:2]);
        if (s_tdata[1:0] == MODE_SPARE) spare_mode_count++;
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, table_shadow.pending());
        $display("hash_set_add_delete_lookup: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] kmax, kmin, kones, b0_a, b0_b, b0_c;
    kmax  = 64'h7fff_ffff_ffff_ffff;   // bucket 1023
    kmin  = 64'h8000_0000_0000_0000;   // bucket 0
    kones = 64'hffff_ffff_ffff_ffff;   // bucket 1023
    b0_a  = 64'(TB_BUCKETS);           // more bucket-0 keys
    b0_b  = 64'(2 * TB_BUCKETS);
    b0_c  = 64'(3 * TB_BUCKETS);
    idle_cycles = 0;
    spare_mode_count = 0;
    src_calm = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, duplicates, spare code, extremes, full bucket,
    // slot reuse after delete, deletes of absent keys
    send_request(hsadl_pkg::MODE_SEARCH, 64'd0);
    send_request(hsadl_pkg::MODE_ADD,    64'd0);
    send_request(hsadl_pkg::MODE_ADD,    64'd0);       // duplicate add
    send_request(hsadl_pkg::MODE_SEARCH, 64'd0);
    send_request(MODE_SPARE,             64'd0);       // acts as search
    send_request(hsadl_pkg::MODE_ADD,    kmax);
    send_request(hsadl_pkg::MODE_ADD,    kmin);
    send_request(hsadl_pkg::MODE_ADD,    kones);
    send_request(hsadl_pkg::MODE_DEL,    b0_a);        // absent
    send_request(hsadl_pkg::MODE_ADD,    b0_a);
    send_request(hsadl_pkg::MODE_ADD,    b0_b);        // bucket 0 now full
    send_request(hsadl_pkg::MODE_ADD,    b0_c);        // overflow
    send_request(hsadl_pkg::MODE_SEARCH, b0_c);
    send_request(hsadl_pkg::MODE_DEL,    kmin);        // frees way 1
    send_request(hsadl_pkg::MODE_ADD,    b0_c);        // lands in the freed way
    send_request(hsadl_pkg::MODE_SEARCH, b0_c);
    send_request(hsadl_pkg::MODE_SEARCH, kmin);
    send_request(hsadl_pkg::MODE_DEL,    64'd0);
    send_request(hsadl_pkg::MODE_DEL,    64'd0);       // already gone
    send_request(MODE_SPARE,             kones);
    send_request(hsadl_pkg::MODE_DEL,    kones);
    send_request(hsadl_pkg::MODE_SEARCH, kmax);
    send_request(hsadl_pkg::MODE_ADD,    kmin);        // way 0 is free again

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i % 40 == 0) src_calm = ($urandom_range(0, 4) == 0);
      send_request(pick_mode(), pick_key());
    end
    s_tvalid <= 1'b0;

    while (table_shadow.pending() != 0) @(posedge clk);
    // anything extra would show up as an unexpected result here
    repeat (2 * LATENCY + 2 * MAX_WAIT) @(posedge clk);

    $display("%0d requests (%0d with the spare mode code), %0d results",
             table_shadow.requests, spare_mode_count, table_shadow.results);
    $display("%0d found keys present, %0d adds dropped on a full bucket",
             table_shadow.hits, table_shadow.overflows);
    if (table_shadow.errors == 0) begin
      $display("hash_set_add_delete_lookup: match");
    end else begin
      $display("hash_set_add_delete_lookup: mismatch");
    end
    $finish;
  end

endmodule
